### rtl/core/srint4_pkg.sv
`default_nettype none
package srint4_pkg;

  localparam int FRAC_BITS = 16;                // fraction bits kept, range 8..24
  localparam int FIX_W     = FRAC_BITS + 6;     // signed fixed point, |v| <= 32
  localparam int WIDE_W    = 29;                // mantissa plus five zero bits appended below it
  localparam int SHIFT_BASE = 155 - FRAC_BITS;  // right shift = SHIFT_BASE - biased exponent

  localparam logic [31:0] LCG_MUL    = 32'd1103515245;
  localparam logic [31:0] LCG_ADD    = 32'd12345;
  localparam logic [31:0] SEED_RESET = 32'hACE1_BEEF;

  localparam logic [7:0] EXP_SPECIAL = 8'hFF;
  localparam logic [7:0] EXP_LIMIT   = 8'd132;  // magnitude of 32 or more from here

  localparam logic signed [3:0] INT4_MAX = 4'sd7;
  localparam logic signed [3:0] INT4_MIN = -4'sd8;

  typedef struct packed {
    logic load;  // reload the generator from the seed
    logic step;  // advance once for an accepted word
  } lcg_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/srint4_lcg.sv
`default_nettype none
module srint4_lcg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire srint4_pkg::lcg_ctrl_t         ctrl,
  input  wire logic [31:0]                   seed,
  output logic [srint4_pkg::FRAC_BITS-1:0]   rnd
);
  import srint4_pkg::*;

  logic [31:0] state_r;
  logic [31:0] state_nxt;
  logic [31:0] stepped;

  assign stepped = state_r * LCG_MUL + LCG_ADD;
  // random number of the word being accepted this cycle
  assign rnd     = stepped[31 -: FRAC_BITS];

  always_comb begin
    state_nxt = state_r;
    if (ctrl.load) begin
      state_nxt = seed;
    end else if (ctrl.step) begin
      state_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEED_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/srint4_round.sv
`default_nettype none
module srint4_round (
  input  wire logic [31:0]                      float_bits,
  input  wire logic [srint4_pkg::FRAC_BITS-1:0] rnd,
  output logic signed [3:0]                     rounded_value,
  output logic                                  clipped
);
  import srint4_pkg::*;

  logic                      sign;
  logic [7:0]                expo;
  logic [22:0]               frac23;
  logic [23:0]               mant;
  logic [7:0]                expo_eff;
  logic [8:0]                shift;
  logic [WIDE_W-1:0]         wide;
  logic [WIDE_W-1:0]         shifted;
  logic [WIDE_W-1:0]         lost_mask;
  logic [FRAC_BITS+4:0]      q;
  logic                      sticky;
  logic [FIX_W-1:0]          mag;
  logic signed [FIX_W-1:0]   fixed;
  logic signed [5:0]         fl;
  logic [FRAC_BITS-1:0]      fr;
  logic signed [6:0]         sum;
  logic                      is_nan;
  logic                      is_big;

  assign sign     = float_bits[31];
  assign expo     = float_bits[30:23];
  assign frac23   = float_bits[22:0];
  assign mant     = {(expo != 8'd0), frac23};
  assign expo_eff = (expo == 8'd0) ? 8'd1 : expo;
  // wraps for large exponents, which take the saturation path anyway
  assign shift    = 9'(SHIFT_BASE) - {1'b0, expo_eff};
  assign wide     = {mant, 5'b0};

  always_comb begin
    if (shift >= 9'(WIDE_W)) begin
      shifted   = '0;
      lost_mask = '1;
    end else begin
      shifted   = wide >> shift[4:0];
      lost_mask = ~({WIDE_W{1'b1}} << shift[4:0]);
    end
  end

  assign q      = shifted[FRAC_BITS+4:0];
  assign sticky = |(wide & lost_mask);

  // floor of a negative value: round the magnitude up before negating
  assign mag   = {1'b0, q} + FIX_W'(sign & sticky);
  assign fixed = sign ? -$signed(mag) : $signed(mag);
  assign fl    = fixed[FIX_W-1:FRAC_BITS];
  assign fr    = fixed[FRAC_BITS-1:0];
  assign sum   = {fl[5], fl} + 7'(rnd < fr);

  assign is_nan = (expo == EXP_SPECIAL) && (frac23 != 23'd0);
  assign is_big = (expo >= EXP_LIMIT);

  always_comb begin
    if (is_nan) begin
      rounded_value = 4'sd0;
      clipped       = 1'b1;
    end else if (is_big) begin
      rounded_value = sign ? INT4_MIN : INT4_MAX;
      clipped       = 1'b1;
    end else if (sum > 7'(INT4_MAX)) begin
      rounded_value = INT4_MAX;
      clipped       = 1'b1;
    end else if (sum < 7'(INT4_MIN)) begin
      rounded_value = INT4_MIN;
      clipped       = 1'b1;
    end else begin
      rounded_value = sum[3:0];
      clipped       = 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/core/stochastic_round_float_to_int4.sv
// Pipeline: an accepted word is held in the input stage and moved to the result
// register once that register is free or being read, which raises out_valid.
// Throughput: one word per cycle while out_ready keeps the result register
// draining; the generator's 32-bit multiply-add steps once per accepted word.
// Reset (rst_n low, synchronous) empties both pipeline stages and loads the
// generator with 0xACE1BEEF; a seed write reloads it at once.
`default_nettype none
module stochastic_round_float_to_int4 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_float_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [3:0] out_rounded_value,
  output logic             out_clipped,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_random_seed
);
  import srint4_pkg::*;

  lcg_ctrl_t               lcg_ctrl;
  logic [FRAC_BITS-1:0]    rnd;
  logic                    in_take;
  logic                    s1_adv;
  logic                    s2_free;

  logic                    s1_valid_r, s1_valid_nxt;
  logic [31:0]             s1_bits_r;
  logic [FRAC_BITS-1:0]    s1_rnd_r;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [3:0]       out_value_r;
  logic                    out_clip_r;
  logic signed [3:0]       rnd_value;
  logic                    rnd_clip;

  assign cfg_ready = 1'b1;
  assign s2_free   = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_ready  = !s1_valid_r || s2_free;
  assign in_take   = in_valid && in_ready;

  assign lcg_ctrl.load = cfg_valid && cfg_ready;
  assign lcg_ctrl.step = in_take;

  srint4_lcg u_lcg (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lcg_ctrl),
    .seed  (cfg_random_seed),
    .rnd   (rnd)
  );

  srint4_round u_round (
    .float_bits    (s1_bits_r),
    .rnd           (s1_rnd_r),
    .rounded_value (rnd_value),
    .clipped       (rnd_clip)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_bits_r <= in_float_bits;
      s1_rnd_r  <= rnd;
    end
    if (s1_adv) begin
      out_value_r <= rnd_value;
      out_clip_r  <= rnd_clip;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rounded_value = out_value_r;
  assign out_clipped       = out_clip_r;

  // an accepted word always lands in the input stage
  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted word not held in input stage");

  // a word blocked by a full result register must hold
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_free |=> s1_valid_r && $stable(s1_bits_r) && $stable(s1_rnd_r))
    else $error("input stage overwritten while stalled");

  // clipping only yields a rail value or the NaN zero
  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clip_r |->
      out_value_r == INT4_MAX || out_value_r == INT4_MIN || out_value_r == 4'sd0)
    else $error("clipped result not at a rail");

endmodule
`default_nettype wire

### tb/sv/int4_round_checker.sv
`timescale 1ns / 100ps
module int4_round_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [31:0]       in_float_bits,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic signed [3:0] out_rounded_value,
  input  logic              out_clipped,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [31:0]       cfg_random_seed,
  output int                mismatches,
  output int                pending
);
  import srint4_pkg::*;

  localparam int RANGE_OFFSET = 32;
  localparam int BIAS_SHIFT   = 150;

  typedef struct packed {
    logic signed [3:0] rounded;
    logic              clipped;
  } int4_result_t;

  logic [31:0]  gen_state;
  int           errors;
  int4_result_t expected_words[$];

  // Stochastic round of one float32 word, given the draw from the generator.
  function automatic int4_result_t round_stochastic(input logic [31:0] bits,
                                                    input logic [31:0] draw);
    logic         sgn;
    logic [7:0]   expo;
    logic [22:0]  frac;
    logic [63:0]  mant;
    logic [63:0]  q;
    logic [63:0]  base;
    logic [63:0]  u;
    logic [63:0]  frac_part;
    logic         sticky;
    int           sh;
    int           floor_part;
    int           sum;
    int4_result_t res;
    sgn  = bits[31];
    expo = bits[30:23];
    frac = bits[22:0];
    res.clipped = 1'b0;
    res.rounded = 4'sd0;
    if (expo == EXP_SPECIAL && frac != 23'd0) begin
      res.clipped = 1'b1;
    end else if (expo >= EXP_LIMIT) begin
      res.rounded = sgn ? INT4_MIN : INT4_MAX;
      res.clipped = 1'b1;
    end else begin
      mant = (expo == 8'd0) ? {41'd0, frac} : {40'd0, 1'b1, frac};
      sh   = ((expo == 8'd0) ? 1 : int'(expo)) - BIAS_SHIFT + FRAC_BITS;
      if (sh >= 0) begin
        q      = mant << sh;
        sticky = 1'b0;
      end else if (sh <= -32) begin
        q      = 64'd0;
        sticky = (mant != 64'd0);
      end else begin
        q      = mant >> (-sh);
        sticky = ((mant & ((64'd1 << (-sh)) - 64'd1)) != 64'd0);
      end
      // offset keeps the value positive so the floor is a plain shift
      base = 64'(RANGE_OFFSET) << FRAC_BITS;
      u    = sgn ? base - q - 64'(sticky) : base + q;
      floor_part = int'(u >> FRAC_BITS) - RANGE_OFFSET;
      frac_part  = u & ((64'd1 << FRAC_BITS) - 64'd1);
      sum = floor_part + ((64'(draw) < frac_part) ? 1 : 0);
      if (sum > int'(INT4_MAX)) begin
        res.rounded = INT4_MAX;
        res.clipped = 1'b1;
      end else if (sum < int'(INT4_MIN)) begin
        res.rounded = INT4_MIN;
        res.clipped = 1'b1;
      end else begin
        res.rounded = 4'(sum);
      end
    end
    return res;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin : watch
    int4_result_t got;
    int4_result_t want;
    if (!rst_n) begin
      gen_state = SEED_RESET;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.rounded = out_rounded_value;
        got.clipped = out_clipped;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual rounded %0d clipped %0b",
                   $time, got.rounded, got.clipped);
        end else begin
          want = expected_words.pop_front();
          if (got.rounded !== want.rounded) begin
            errors++;
            $display("%0t: rounded_value expected %0d actual %0d",
                     $time, want.rounded, got.rounded);
          end
          if (got.clipped !== want.clipped) begin
            errors++;
            $display("%0t: clipped expected %0b actual %0b",
                     $time, want.clipped, got.clipped);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        gen_state = cfg_random_seed;
      if (in_valid && in_ready) begin
        // advance the generator once per word, NaN and infinity included
        gen_state = gen_state * LCG_MUL + LCG_ADD;
        expected_words.push_back(round_stochastic(in_float_bits,
                                                  gen_state >> (32 - FRAC_BITS)));
      end
    end
    pending    <= expected_words.size();
    mismatches <= errors;
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 407;
  localparam int NUM_PHASES     = 4;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [31:0]       in_float_bits = 32'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [3:0] out_rounded_value;
  logic              out_clipped;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_random_seed = 32'd0;

  int mismatches;
  int pending;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  stochastic_round_float_to_int4 u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_float_bits     (in_float_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rounded_value (out_rounded_value),
    .out_clipped       (out_clipped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_random_seed   (cfg_random_seed)
  );

  int4_round_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_float_bits     (in_float_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rounded_value (out_rounded_value),
    .out_clipped       (out_clipped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_random_seed   (cfg_random_seed),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // end the run if no channel moves a word for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_float_bits <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    cfg_valid       <= 1'b1;
    cfg_random_seed <= seed;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // bias towards the -8..7 neighbourhood, with subnormals, specials and raw noise
  function automatic logic [31:0] pick_float();
    int          pick;
    logic        sgn;
    logic [7:0]  expo;
    logic [22:0] frac;
    pick = $urandom_range(99);
    sgn  = 1'($urandom_range(1));
    frac = 23'($urandom);
    if (pick < 55) begin
      expo = 8'($urandom_range(132, 118));
    end else if (pick < 65) begin
      expo = 8'd0;
      if ($urandom_range(3) == 0) frac = 23'd0;
    end else if (pick < 75) begin
      expo = 8'hFF;
      if ($urandom_range(1) == 0) frac = 23'd0;
    end else begin
      return $urandom;
    end
    return {sgn, expo, frac};
  endfunction

  logic [31:0] edge_words[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFF80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h8000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
    32'h3FC0_0000, 32'hBFC0_0000, 32'h40F0_0000, 32'hC108_0000,
    32'h40E0_0000, 32'hC100_0000, 32'h41FF_FFFF, 32'hC1FF_FFFF,
    32'h4200_0000, 32'hC200_0000, 32'h3F00_0000, 32'hBF00_0000
  };

  int          phase_src[NUM_PHASES]  = '{0, 54, 0, 10};
  int          phase_sink[NUM_PHASES] = '{0, 0, 54, 10};
  logic [31:0] phase_seed[NUM_PHASES];

  initial begin
    phase_seed = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // directed words run on the seed loaded at reset
    foreach (edge_words[i]) send_word(edge_words[i]);
    drain();
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_seed(phase_seed[p]);
      src_idle_pct   = phase_src[p];
      sink_stall_pct = phase_sink[p];
      repeat (RANDOM_WORDS) send_word(pick_float());
      drain();
    end
    // catch any stray word after the last expected one
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
